>>> sv/m2u_pkg.sv
// ----------------------------------------------------------------------------
// m2u_pkg
// Shared types and constants for the MIDI to USB-MIDI event packetizer.
// ----------------------------------------------------------------------------
package m2u_pkg;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] CAP_RESET   = 8'd20;

    // Status nibbles of channel messages
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY_PRES = 4'hA;
    localparam logic [3:0] ST_CTRL_CHG  = 4'hB;
    localparam logic [3:0] ST_PROG_CHG  = 4'hC;
    localparam logic [3:0] ST_CHAN_PRES = 4'hD;
    localparam logic [3:0] ST_PITCH     = 4'hE;

    // Code index numbers for SysEx
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;

    localparam logic [1:0] MSG_LEN_2 = 2'd2;
    localparam logic [1:0] MSG_LEN_3 = 2'd3;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_OVERFLOW     = 3'd1,
        ERR_UNTERMINATED = 3'd2,
        ERR_TRUNCATED    = 3'd3,
        ERR_UNEXPECTED   = 3'd4
    } t_err;

    // One result word
    typedef struct packed {
        logic       packet_valid;
        logic [3:0] code_index;
        logic [7:0] packet_byte1;
        logic [7:0] packet_byte2;
        logic [7:0] packet_byte3;
        logic       batch_done;
        logic [7:0] packet_total;
        t_err       error_code;
    } t_usb_word;

endpackage

>>> sv/m2u_if.sv
// ----------------------------------------------------------------------------
// m2u interfaces
// Valid/ready channels for raw MIDI bytes in and event packets out.
// ----------------------------------------------------------------------------
interface m2u_midi_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;
    logic       last_byte;

    modport source (output valid, output midi_byte, output last_byte, input ready);
    modport sink   (input valid, input midi_byte, input last_byte, output ready);
endinterface

interface m2u_usb_if;
    logic             valid;
    logic             ready;
    logic             packet_valid;
    logic [3:0]       code_index;
    logic [7:0]       packet_byte1;
    logic [7:0]       packet_byte2;
    logic [7:0]       packet_byte3;
    logic             batch_done;
    logic [7:0]       packet_total;
    logic [2:0]       error_code;

    modport source (output valid, output packet_valid, output code_index,
                    output packet_byte1, output packet_byte2, output packet_byte3,
                    output batch_done, output packet_total, output error_code,
                    input ready);
    modport sink   (input valid, input packet_valid, input code_index,
                    input packet_byte1, input packet_byte2, input packet_byte3,
                    input batch_done, input packet_total, input error_code,
                    output ready);
endinterface

>>> sv/midi_to_usb_midi_packetizer.sv
// ----------------------------------------------------------------------------
// midi_to_usb_midi_packetizer
// Packs raw MIDI bytes into USB-MIDI event packets on cable 0.
// ----------------------------------------------------------------------------
// Output: each result word is registered; a skid stage absorbs one output stall.
// Throughput: one byte per cycle while the skid stage is empty; the byte
//   decision is a single pass of logic over two held bytes.
// Reset (i_rst_n, synchronous, active low): batch state cleared, no error,
//   capacity back to 20 slots, output buffer empty.
// ----------------------------------------------------------------------------
module midi_to_usb_midi_packetizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    m2u_midi_if.sink   i_midi,
    m2u_usb_if.source  o_usb
);

    logic               fire;
    logic               push;
    logic               buf_ready;
    m2u_pkg::t_usb_word enc_word;
    m2u_pkg::t_usb_word out_word;

    // A byte is taken whenever the skid stage is free; the encoder
    // updates batch state on that same edge.
    assign i_midi.ready = buf_ready;
    assign fire         = i_midi.valid && buf_ready;

    // Byte decision: SysEx chunking, channel message assembly,
    // slot counting and the sticky error.
    m2u_encoder u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_midi_byte (i_midi.midi_byte),
        .i_last_byte (i_midi.last_byte),
        .o_push      (push),
        .o_word      (enc_word)
    );

    // Result register plus one skid word
    m2u_out_buf u_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_word       (enc_word),
        .o_ready      (buf_ready),
        .o_valid      (o_usb.valid),
        .i_take_ready (o_usb.ready),
        .o_word       (out_word)
    );

    assign o_usb.packet_valid = out_word.packet_valid;
    assign o_usb.code_index   = out_word.code_index;
    assign o_usb.packet_byte1 = out_word.packet_byte1;
    assign o_usb.packet_byte2 = out_word.packet_byte2;
    assign o_usb.packet_byte3 = out_word.packet_byte3;
    assign o_usb.batch_done   = out_word.batch_done;
    assign o_usb.packet_total = out_word.packet_total;
    assign o_usb.error_code   = out_word.error_code;

endmodule

>>> sv/m2u_encoder.sv
// ----------------------------------------------------------------------------
// m2u_encoder
// Per-byte packet builder: held bytes, SysEx flag, counter, sticky error.
// ----------------------------------------------------------------------------
module m2u_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_fire,
    input  logic [7:0]          i_midi_byte,
    input  logic                i_last_byte,
    output logic                o_push,
    output m2u_pkg::t_usb_word  o_word
);

    logic [7:0]    r_cap;
    logic          r_sysex, n_sysex;
    logic [1:0]    r_held, n_held;
    logic [7:0]    r_hb0, n_hb0;
    logic [7:0]    r_hb1, n_hb1;
    logic [1:0]    r_len, n_len;
    logic [7:0]    r_cnt, n_cnt;
    m2u_pkg::t_err r_err, n_err;

    logic          pkt;
    logic [3:0]    cin;
    logic [7:0]    p1, p2, p3;
    logic [3:0]    hi;
    logic [2:0]    held_inc;

    assign hi       = i_midi_byte[7:4];
    assign held_inc = {1'b0, r_held} + 3'd1;

    always_comb begin
        n_sysex = r_sysex;
        n_held  = r_held;
        n_hb0   = r_hb0;
        n_hb1   = r_hb1;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_err   = r_err;
        pkt     = 1'b0;
        cin     = '0;
        p1      = '0;
        p2      = '0;
        p3      = '0;

        if (r_err == m2u_pkg::ERR_NONE) begin
            if (r_held == 2'd0 && r_cnt >= r_cap) begin
                n_err = m2u_pkg::ERR_OVERFLOW;
            end else if (r_sysex || (r_held == 2'd0 && i_midi_byte == m2u_pkg::SYSEX_START)) begin
                n_sysex = 1'b1;
                if (i_midi_byte == m2u_pkg::SYSEX_END || r_held == 2'd2) begin
                    pkt = 1'b1;
                    p1  = (r_held != 2'd0) ? r_hb0 : i_midi_byte;
                    p2  = (r_held == 2'd2) ? r_hb1 :
                          (r_held == 2'd1) ? i_midi_byte : 8'h00;
                    p3  = (r_held == 2'd2) ? i_midi_byte : 8'h00;
                    if (i_midi_byte == m2u_pkg::SYSEX_END) begin
                        cin     = m2u_pkg::CIN_SYSEX_END1 + {2'b00, r_held};
                        n_sysex = 1'b0;
                    end else begin
                        cin = m2u_pkg::CIN_SYSEX_CONT;
                    end
                    n_held = 2'd0;
                end else begin
                    if (r_held[0]) n_hb1 = i_midi_byte;
                    else           n_hb0 = i_midi_byte;
                    n_held = held_inc[1:0];
                end
            end else if (r_held == 2'd0) begin
                if (hi inside {m2u_pkg::ST_NOTE_OFF, m2u_pkg::ST_NOTE_ON,
                               m2u_pkg::ST_POLY_PRES, m2u_pkg::ST_CTRL_CHG,
                               m2u_pkg::ST_PITCH}) begin
                    n_len  = m2u_pkg::MSG_LEN_3;
                    n_hb0  = i_midi_byte;
                    n_held = 2'd1;
                end else if (hi inside {m2u_pkg::ST_PROG_CHG, m2u_pkg::ST_CHAN_PRES}) begin
                    n_len  = m2u_pkg::MSG_LEN_2;
                    n_hb0  = i_midi_byte;
                    n_held = 2'd1;
                end else begin
                    n_err = m2u_pkg::ERR_UNEXPECTED;
                end
            end else begin
                if (held_inc >= {1'b0, r_len}) begin
                    pkt = 1'b1;
                    cin = r_hb0[7:4];
                    p1  = r_hb0;
                    if (r_len == m2u_pkg::MSG_LEN_3 && r_held == 2'd2) begin
                        p2 = r_hb1;
                        p3 = i_midi_byte;
                    end else begin
                        p2 = i_midi_byte;
                    end
                    n_held = 2'd0;
                    n_len  = 2'd0;
                end else begin
                    if (r_held[0]) n_hb1 = i_midi_byte;
                    else           n_hb0 = i_midi_byte;
                    n_held = held_inc[1:0];
                end
            end
            if (pkt) n_cnt = r_cnt + 8'd1;
        end

        // End-of-batch checks see the state after this byte
        if (i_last_byte && n_err == m2u_pkg::ERR_NONE) begin
            if (n_sysex)              n_err = m2u_pkg::ERR_UNTERMINATED;
            else if (n_held != 2'd0)  n_err = m2u_pkg::ERR_TRUNCATED;
        end

        o_word.packet_valid = pkt;
        o_word.code_index   = cin;
        o_word.packet_byte1 = p1;
        o_word.packet_byte2 = p2;
        o_word.packet_byte3 = p3;
        o_word.batch_done   = i_last_byte;
        o_word.packet_total = i_last_byte ? n_cnt : 8'd0;
        o_word.error_code   = i_last_byte ? n_err : m2u_pkg::ERR_NONE;
    end

    assign o_push = i_fire && (pkt || i_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= m2u_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap   <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sysex <= 1'b0;
            r_held  <= '0;
            r_hb0   <= '0;
            r_hb1   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_err   <= m2u_pkg::ERR_NONE;
        end else if (i_fire) begin
            if (i_last_byte) begin
                r_sysex <= 1'b0;
                r_held  <= '0;
                r_hb0   <= '0;
                r_hb1   <= '0;
                r_len   <= '0;
                r_cnt   <= '0;
                r_err   <= m2u_pkg::ERR_NONE;
            end else begin
                r_sysex <= n_sysex;
                r_held  <= n_held;
                r_hb0   <= n_hb0;
                r_hb1   <= n_hb1;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
                r_err   <= n_err;
            end
        end
    end

endmodule

>>> sv/m2u_out_buf.sv
// ----------------------------------------------------------------------------
// m2u_out_buf
// Output register with a skid stage so the input side keeps flowing.
// ----------------------------------------------------------------------------
module m2u_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  m2u_pkg::t_usb_word  i_word,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_take_ready,
    output m2u_pkg::t_usb_word  o_word
);

    logic               r_out_valid;
    logic               r_skid_valid;
    m2u_pkg::t_usb_word r_out;
    m2u_pkg::t_usb_word r_skid;
    logic               take;

    assign take    = r_out_valid && i_take_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            if (r_skid_valid) r_out <= r_skid;
            else              r_out <= i_word;
        end else if (i_push) begin
            r_skid <= i_word;
        end
    end

endmodule

>>> tb/sv/m2u_scoreboard.sv
// ----------------------------------------------------------------------------
// m2u_scoreboard
// Watches the MIDI byte and USB packet channels of the packetizer, keeps its
// own copy of the batch state and capacity, and checks each output word
// field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module m2u_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    m2u_midi_if         i_midi,
    m2u_usb_if          i_usb,
    output int unsigned o_pending,
    output int unsigned o_errors
);

    logic [7:0]    slot_cap;
    logic          sysex_on;
    logic [1:0]    held_cnt;
    logic [7:0]    held [2];
    logic [1:0]    msg_len;
    logic [7:0]    pkt_cnt;
    m2u_pkg::t_err err_latch;

    m2u_pkg::t_usb_word pending_packets [$];
    int unsigned        errors = 0;

    function automatic void clear_batch();
        sysex_on  = 1'b0;
        held_cnt  = '0;
        held[0]   = '0;
        held[1]   = '0;
        msg_len   = '0;
        pkt_cnt   = '0;
        err_latch = m2u_pkg::ERR_NONE;
    endfunction

    // One byte of the batch; queues the word it causes, if any.
    task automatic encode_midi_byte(input logic [7:0] b, input logic last);
        m2u_pkg::t_usb_word w;
        logic               pkt;
        w   = '0;
        pkt = 1'b0;
        if (err_latch == m2u_pkg::ERR_NONE) begin
            if (held_cnt == 2'd0 && pkt_cnt >= slot_cap) begin
                err_latch = m2u_pkg::ERR_OVERFLOW;
            end else if (sysex_on || (held_cnt == 2'd0 && b == m2u_pkg::SYSEX_START)) begin
                sysex_on = 1'b1;
                if (b == m2u_pkg::SYSEX_END || held_cnt == 2'd2) begin
                    pkt            = 1'b1;
                    w.packet_byte1 = (held_cnt > 2'd0) ? held[0] : b;
                    w.packet_byte2 = (held_cnt > 2'd1) ? held[1] :
                                     ((held_cnt == 2'd1) ? b : 8'h00);
                    w.packet_byte3 = (held_cnt == 2'd2) ? b : 8'h00;
                    if (b == m2u_pkg::SYSEX_END) begin
                        w.code_index = m2u_pkg::CIN_SYSEX_END1 + {2'b00, held_cnt};
                        sysex_on     = 1'b0;
                    end else begin
                        w.code_index = m2u_pkg::CIN_SYSEX_CONT;
                    end
                    held_cnt = '0;
                end else begin
                    held[held_cnt[0]] = b;
                    held_cnt++;
                end
            end else if (held_cnt == 2'd0) begin
                case (b[7:4])
                    m2u_pkg::ST_NOTE_OFF, m2u_pkg::ST_NOTE_ON, m2u_pkg::ST_POLY_PRES,
                    m2u_pkg::ST_CTRL_CHG, m2u_pkg::ST_PITCH: begin
                        msg_len  = m2u_pkg::MSG_LEN_3;
                        held[0]  = b;
                        held_cnt = 2'd1;
                    end
                    m2u_pkg::ST_PROG_CHG, m2u_pkg::ST_CHAN_PRES: begin
                        msg_len  = m2u_pkg::MSG_LEN_2;
                        held[0]  = b;
                        held_cnt = 2'd1;
                    end
                    default: begin
                        err_latch = m2u_pkg::ERR_UNEXPECTED;
                    end
                endcase
            end else begin
                if (({1'b0, held_cnt} + 3'd1) >= {1'b0, msg_len}) begin
                    pkt            = 1'b1;
                    w.code_index   = held[0][7:4];
                    w.packet_byte1 = held[0];
                    if (msg_len == m2u_pkg::MSG_LEN_3 && held_cnt == 2'd2) begin
                        w.packet_byte2 = held[1];
                        w.packet_byte3 = b;
                    end else begin
                        w.packet_byte2 = b;
                    end
                    held_cnt = '0;
                    msg_len  = '0;
                end else begin
                    held[held_cnt[0]] = b;
                    held_cnt++;
                end
            end
            if (pkt) begin
                pkt_cnt++;
            end
        end
        if (pkt || last) begin
            w.packet_valid = pkt;
            if (last) begin
                if (err_latch == m2u_pkg::ERR_NONE) begin
                    if (sysex_on) begin
                        err_latch = m2u_pkg::ERR_UNTERMINATED;
                    end else if (held_cnt != 2'd0) begin
                        err_latch = m2u_pkg::ERR_TRUNCATED;
                    end
                end
                w.batch_done   = 1'b1;
                w.packet_total = pkt_cnt;
                w.error_code   = err_latch;
                clear_batch();
            end
            pending_packets.push_back(w);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        m2u_pkg::t_usb_word w;
        if (!i_rst_n) begin
            slot_cap = m2u_pkg::CAP_RESET;
            clear_batch();
            pending_packets.delete();
        end else begin
            if (i_cfg_we) begin
                slot_cap = i_cfg_wdata;
            end
            if (i_midi.valid && i_midi.ready) begin
                encode_midi_byte(i_midi.midi_byte, i_midi.last_byte);
            end
            if (i_usb.valid && i_usb.ready) begin
                if (pending_packets.size() == 0) begin
                    $display("%0t: word with none expected, got %0h %0h %0h %0h",
                             $time, i_usb.code_index, i_usb.packet_byte1,
                             i_usb.packet_byte2, i_usb.packet_byte3);
                    errors++;
                end else begin
                    w = pending_packets.pop_front();
                    compare_field("packet_valid", 8'(w.packet_valid),
                                  8'(i_usb.packet_valid));
                    compare_field("code_index", 8'(w.code_index), 8'(i_usb.code_index));
                    compare_field("packet_byte1", w.packet_byte1, i_usb.packet_byte1);
                    compare_field("packet_byte2", w.packet_byte2, i_usb.packet_byte2);
                    compare_field("packet_byte3", w.packet_byte3, i_usb.packet_byte3);
                    compare_field("batch_done", 8'(w.batch_done), 8'(i_usb.batch_done));
                    compare_field("packet_total", w.packet_total, i_usb.packet_total);
                    compare_field("error_code", 8'(w.error_code), 8'(i_usb.error_code));
                end
            end
        end
        o_pending <= unsigned'(pending_packets.size());
        o_errors  <= errors;
    end

endmodule

>>> tb/sv/tb_midi_to_usb_midi_packetizer.sv
// ----------------------------------------------------------------------------
// tb_midi_to_usb_midi_packetizer
// Drives batches of raw MIDI bytes into the packetizer under changing slot
// capacities and idle/stall patterns; the scoreboard beside the block
// predicts every packet and batch summary and counts mismatches.
// ----------------------------------------------------------------------------
module tb_midi_to_usb_midi_packetizer;

    localparam int unsigned SEG_COUNT    = 8;
    localparam int unsigned SEG_BYTES    = 225;  // ~1800 random bytes overall
    localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int unsigned SETTLE_TICKS = 4;    // output latency plus skid stage

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    int unsigned pending;
    int unsigned mismatches;

    m2u_midi_if midi_ch ();
    m2u_usb_if  usb_ch ();

    midi_to_usb_midi_packetizer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_midi      (midi_ch),
        .o_usb       (usb_ch)
    );

    m2u_scoreboard scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_midi      (midi_ch),
        .i_usb       (usb_ch),
        .o_pending   (pending),
        .o_errors    (mismatches)
    );

    // Channel message status nibbles, picked at random for well-formed batches
    logic [3:0] status_kinds [7] = '{m2u_pkg::ST_NOTE_OFF, m2u_pkg::ST_NOTE_ON,
                                     m2u_pkg::ST_POLY_PRES, m2u_pkg::ST_CTRL_CHG,
                                     m2u_pkg::ST_PROG_CHG, m2u_pkg::ST_CHAN_PRES,
                                     m2u_pkg::ST_PITCH};

    logic [7:0]  batch_bytes [$];   // batch under construction
    int unsigned seg_sent;          // bytes accepted in the current segment
    int unsigned send_idle_pct;     // sender idle odds, percent
    int unsigned stall_pct = 0;     // receiver stall odds, percent
    int unsigned hold_reqs = 0;     // bumped to ask for a long hold-off
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the run hangs, e.g. words never drain.
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request, counted here.
    always @(posedge clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            usb_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            usb_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Mostly 7-bit data; now and then any value, since the block takes
    // whatever follows a status as data.
    function automatic logic [7:0] data_byte();
        if ($urandom_range(7, 0) == 0) begin
            return 8'($urandom_range(255, 0));
        end
        return 8'($urandom_range(127, 0));
    endfunction

    // Fills batch_bytes: mostly well-formed message runs with random content,
    // some broken runs (stray bytes, chopped tail), some pure noise.
    function automatic void build_batch();
        int unsigned kind;
        logic [3:0]  st;
        batch_bytes.delete();
        kind = $urandom_range(99, 0);
        if (kind < 10) begin
            repeat ($urandom_range(8, 1)) batch_bytes.push_back(8'($urandom_range(255, 0)));
            return;
        end
        repeat ($urandom_range(6, 1)) begin
            if (kind >= 75 && $urandom_range(3, 0) == 0) begin
                batch_bytes.push_back(8'($urandom_range(255, 0)));
            end
            if ($urandom_range(3, 0) == 0) begin
                // SysEx of 0..7 payload bytes: hits every closing code index
                batch_bytes.push_back(m2u_pkg::SYSEX_START);
                repeat ($urandom_range(7, 0)) batch_bytes.push_back(data_byte());
                batch_bytes.push_back(m2u_pkg::SYSEX_END);
            end else begin
                st = status_kinds[$urandom_range(6, 0)];
                batch_bytes.push_back({st, 4'($urandom_range(15, 0))});
                batch_bytes.push_back(data_byte());
                if (st != m2u_pkg::ST_PROG_CHG && st != m2u_pkg::ST_CHAN_PRES) begin
                    batch_bytes.push_back(data_byte());
                end
            end
        end
        // broken run: drop the tail byte so the last message or SysEx is cut
        if (kind >= 75 && $urandom_range(1, 0) == 0 && batch_bytes.size() > 1) begin
            void'(batch_bytes.pop_back());
        end
    endfunction

    // One MIDI word: random idle gaps first, then hold it until taken.
    task automatic send_word(input logic [7:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            midi_ch.valid <= 1'b0;
            @(posedge clk);
        end
        midi_ch.valid     <= 1'b1;
        midi_ch.midi_byte <= b;
        midi_ch.last_byte <= last;
        @(posedge clk);
        while (!midi_ch.ready) @(posedge clk);
    endtask

    task automatic send_batch();
        foreach (batch_bytes[k]) begin
            send_word(batch_bytes[k], k == batch_bytes.size() - 1);
            seg_sent++;
        end
    endtask

    // Sender pauses until every predicted word is out, then lets the
    // pipeline settle for bytes that cause no word.
    task automatic wait_drained();
        midi_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Capacity is only written with the block idle and between batches.
    task automatic write_capacity(input logic [7:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned seg;
        logic [7:0]  cap;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        midi_ch.valid     = 1'b0;
        midi_ch.midi_byte = '0;
        midi_ch.last_byte = 1'b0;
        send_idle_pct     = 0;
        seg_sent          = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset capacity of 20 slots ----
        // note off with high data, channel pressure, SysEx closed by F7 alone
        batch_bytes = '{8'h80, 8'hFF, 8'h00, 8'hD3, 8'h55, 8'hF0, 8'h11, 8'h22, 8'hF7};
        send_batch();
        // data byte where a status belongs
        batch_bytes = '{8'h7F, 8'h90};
        send_batch();
        // poly pressure cut short
        batch_bytes = '{8'hA1, 8'h10};
        send_batch();
        // SysEx never closed
        batch_bytes = '{m2u_pkg::SYSEX_START, 8'h01};
        send_batch();
        // pitch bend, full chunk, then F0 at a chunk boundary inside SysEx
        batch_bytes = '{8'hE5, 8'h00, 8'h7F, m2u_pkg::SYSEX_START, 8'h01, 8'h02,
                        m2u_pkg::SYSEX_START, m2u_pkg::SYSEX_END};
        send_batch();
        // one slot only: the second program change overflows
        wait_drained();
        write_capacity(8'd1);
        batch_bytes = '{8'hC0, 8'h01, 8'hC0};
        send_batch();

        // ---- random part: four idle patterns, two capacities each ----
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            wait_drained();
            case (seg / 2)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 76; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 76; end
                default: begin send_idle_pct = 24; stall_pct <= 24; end
            endcase
            case (seg)
                0:       cap = 8'd255;
                1:       cap = 8'd1;
                3:       cap = 8'($urandom_range(255, 1));
                5:       cap = 8'd255;
                7:       cap = m2u_pkg::CAP_RESET;
                default: cap = 8'($urandom_range(8, 2));
            endcase
            write_capacity(cap);
            // first segment: receiver holds off while bytes keep coming,
            // so the block fills up and drops ready
            if (seg == 0) begin
                hold_reqs <= hold_reqs + 1;
            end
            seg_sent = 0;
            while (seg_sent < SEG_BYTES) begin
                build_batch();
                send_batch();
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
